// ===== src/sap_pkg.sv =====
// Shared types, constants and compare helpers for the sweep-and-prune core.
// Used by sap_ctrl, sap_dpath and the top level; no dependencies.
`default_nettype none
package sap_pkg;

    localparam int MAX_BOXES = 64;
    localparam int SLOT_W    = $clog2(MAX_BOXES);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int MAX_PAIRS = 1024;
    localparam int PAIR_W    = $clog2(MAX_PAIRS);
    localparam int STORED_W  = PAIR_W + 1;
    localparam int RES_CAP   = 64;
    localparam int COORD_W   = 32;
    localparam int ENT_W     = 16;
    localparam int KEY_W     = 7;
    localparam int KIND_W    = 3;
    localparam int LIMIT_W   = 7;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT = 3'd0,
        K_UPDATE = 3'd1,
        K_REMOVE = 3'd2,
        K_STEP   = 3'd3,
        K_READ   = 3'd4,
        K_QUERY  = 3'd5
    } t_kind;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAP,
        OP_INS_STACK,
        OP_INS_FRESH,
        OP_INS_FULL,
        OP_UPDATE,
        OP_REMOVE,
        OP_RD_PAIR,
        OP_RD_BAD,
        OP_EMIT,
        OP_RK_START,
        OP_RK_SKIP,
        OP_RK_LOAD,
        OP_RK_STEP,
        OP_RK_WRITE,
        OP_PR_START,
        OP_PR_B,
        OP_PR_STEP,
        OP_PR_NEXT,
        OP_Q_START,
        OP_Q_NEXT,
        OP_Q_TAKE,
        OP_Q_SWAP,
        OP_Q_END
    } t_op;

    typedef struct packed {
        t_kind kind;
        logic  free_nonempty;
        logic  slots_avail;
        logic  key_ok;
        logic  idx_ok;
        logic  s_end;
        logic  s_alive;
        logic  rk_done;
        logic  pr_end;
        logic  pr_done;
        logic  q_stop;
        logic  q_hit;
        logic  pend;
        logic  out_free;
    } t_status;

    typedef struct packed {
        logic [COORD_W-1:0] lx;
        logic [COORD_W-1:0] ly;
        logic [COORD_W-1:0] lz;
        logic [COORD_W-1:0] ux;
        logic [COORD_W-1:0] uy;
        logic [COORD_W-1:0] uz;
    } t_box;

    function automatic logic s_lt(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // inclusive interval overlap
    function automatic logic ov1(input logic [COORD_W-1:0] amin, input logic [COORD_W-1:0] amax,
                                 input logic [COORD_W-1:0] bmin, input logic [COORD_W-1:0] bmax);
        return !s_lt(amax, bmin) && !s_lt(bmax, amin);
    endfunction

endpackage
`default_nettype wire

// ===== src/sap_ctrl.sv =====
// Controller state machine: sequences table ops, the step (rank, then sweep)
// and the query scan. Depends on sap_pkg; drives sap_dpath by op codes.
`default_nettype none
module sap_ctrl
    import sap_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  t_status i_st,
    output t_op     o_op
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DECODE   = 12'b0000_0000_0010,
        S_RD_WAIT  = 12'b0000_0000_0100,
        S_EMIT     = 12'b0000_0000_1000,
        S_RK_OUTER = 12'b0000_0001_0000,
        S_RK_SCAN  = 12'b0000_0010_0000,
        S_PR_OUTER = 12'b0000_0100_0000,
        S_PR_B1    = 12'b0000_1000_0000,
        S_PR_SCAN  = 12'b0001_0000_0000,
        S_Q_CHECK  = 12'b0010_0000_0000,
        S_Q_EVAL   = 12'b0100_0000_0000,
        S_Q_END    = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_CAP;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_st.kind)
                    K_INSERT: begin
                        if (i_st.free_nonempty)    o_op = OP_INS_STACK;
                        else if (i_st.slots_avail) o_op = OP_INS_FRESH;
                        else                       o_op = OP_INS_FULL;
                        n_state = S_EMIT;
                    end
                    K_UPDATE: begin
                        if (i_st.key_ok) o_op = OP_UPDATE;
                        n_state = S_IDLE;
                    end
                    K_REMOVE: begin
                        if (i_st.key_ok) o_op = OP_REMOVE;
                        n_state = S_IDLE;
                    end
                    K_STEP: begin
                        o_op    = OP_RK_START;
                        n_state = S_RK_OUTER;
                    end
                    K_READ: begin
                        if (i_st.idx_ok) begin
                            o_op    = OP_RD_PAIR;
                            n_state = S_RD_WAIT;
                        end else begin
                            o_op    = OP_RD_BAD;
                            n_state = S_EMIT;
                        end
                    end
                    K_QUERY: begin
                        o_op    = OP_Q_START;
                        n_state = S_Q_CHECK;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RD_WAIT: n_state = S_EMIT;
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_op    = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            S_RK_OUTER: begin
                if (i_st.s_end) begin
                    o_op    = OP_PR_START;
                    n_state = S_PR_OUTER;
                end else if (!i_st.s_alive) begin
                    o_op = OP_RK_SKIP;
                end else begin
                    o_op    = OP_RK_LOAD;
                    n_state = S_RK_SCAN;
                end
            end
            S_RK_SCAN: begin
                if (i_st.rk_done) begin
                    o_op    = OP_RK_WRITE;
                    n_state = S_RK_OUTER;
                end else begin
                    o_op = OP_RK_STEP;
                end
            end
            S_PR_OUTER: begin
                if (i_st.pr_end) n_state = S_EMIT;
                else             n_state = S_PR_B1;
            end
            S_PR_B1: begin
                o_op    = OP_PR_B;
                n_state = S_PR_SCAN;
            end
            S_PR_SCAN: begin
                if (i_st.pr_done) begin
                    o_op    = OP_PR_NEXT;
                    n_state = S_PR_OUTER;
                end else begin
                    o_op = OP_PR_STEP;
                end
            end
            S_Q_CHECK: begin
                if (i_st.q_stop)        n_state = S_Q_END;
                else if (!i_st.s_alive) o_op = OP_Q_NEXT;
                else                    n_state = S_Q_EVAL;
            end
            S_Q_EVAL: begin
                if (!i_st.q_hit) begin
                    o_op    = OP_Q_NEXT;
                    n_state = S_Q_CHECK;
                end else if (!i_st.pend) begin
                    o_op    = OP_Q_TAKE;
                    n_state = S_Q_CHECK;
                end else if (i_st.out_free) begin
                    o_op    = OP_Q_SWAP;
                    n_state = S_Q_CHECK;
                end
            end
            S_Q_END: begin
                if (i_st.out_free) begin
                    o_op    = OP_Q_END;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/sap_dpath.sv =====
// Datapath: box table, free stack, endpoint order, pair store, loop counters
// and the output register. Depends on sap_pkg; steered by sap_ctrl op codes.
`default_nettype none
module sap_dpath
    import sap_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  t_op                       i_op,
    output t_status                   o_st,
    input  wire [KIND_W-1:0]          i_kind,
    input  wire [KEY_W-1:0]           i_box_key,
    input  wire [ENT_W-1:0]           i_entity,
    input  wire signed [COORD_W-1:0]  i_min_x,
    input  wire signed [COORD_W-1:0]  i_min_y,
    input  wire signed [COORD_W-1:0]  i_min_z,
    input  wire signed [COORD_W-1:0]  i_max_x,
    input  wire signed [COORD_W-1:0]  i_max_y,
    input  wire signed [COORD_W-1:0]  i_max_z,
    input  wire [PAIR_W-1:0]          i_pair_index,
    input  wire [LIMIT_W-1:0]         i_hit_limit,
    input  wire                       i_out_ready,
    output logic                      o_out_valid,
    output logic [KEY_W-1:0]          o_new_key,
    output logic [STORED_W-1:0]       o_pair_count,
    output logic [ENT_W-1:0]          o_entity_low,
    output logic [ENT_W-1:0]          o_entity_high,
    output logic [ENT_W-1:0]          o_hit_entity,
    output logic                      o_hit_valid,
    output logic                      o_overflow,
    output logic                      o_failure,
    output logic                      o_last
);

    // captured input word
    logic [KIND_W-1:0]   r_q_kind;
    logic [KEY_W-1:0]    r_q_key;
    logic [ENT_W-1:0]    r_q_ent;
    t_box                r_q_box;
    logic [PAIR_W-1:0]   r_q_idx;
    logic [LIMIT_W-1:0]  r_q_lim;

    // table state
    logic [MAX_BOXES-1:0] r_alive;
    logic [CNT_W-1:0]     r_used;
    logic [CNT_W-1:0]     r_depth;
    logic [STORED_W-1:0]  r_stored;
    logic                 r_ovf;

    // memories
    t_box               r_box_mem [MAX_BOXES];
    t_box               r_box_qa, r_box_qb;
    logic [ENT_W-1:0]   r_ent_mem [MAX_BOXES];
    logic [ENT_W-1:0]   r_ent_qa, r_ent_qb;
    logic [SLOT_W-1:0]  r_fs_mem [MAX_BOXES];
    logic [SLOT_W-1:0]  r_fs_q;
    logic [SLOT_W-1:0]  r_ord_mem [MAX_BOXES];
    logic [SLOT_W-1:0]  r_ord_qa, r_ord_qb;
    logic [2*ENT_W-1:0] r_pair_mem [MAX_PAIRS];
    logic [2*ENT_W-1:0] r_pair_q;
    logic [PAIR_W-1:0]  r_pair_addr;

    // loop state
    logic [CNT_W-1:0]   r_s, r_t, r_cnt, r_n, r_hits;
    logic [SLOT_W-1:0]  r_b, r_pt;
    logic               r_p1, r_p2, r_in_pair, r_pend;
    logic [ENT_W-1:0]   r_pend_ent;

    // staged single-result fields
    logic [KEY_W-1:0]   r_res_key;
    logic               r_res_fail, r_res_pair;

    logic [SLOT_W-1:0]  box_addr_a, box_addr_b, ins_slot, box_wa;
    logic [CNT_W-1:0]   key_m1;
    logic               box_we, ent_we, ins_op;
    t_box               box_wd;
    logic [SLOT_W-1:0]  fs_ra;
    logic               rk_less, pr_act, pr_hit, q_hit;
    logic [ENT_W-1:0]   ent_lo, ent_hi;
    logic [LIMIT_W-1:0] lim;
    logic               out_free, pair_we;

    assign key_m1     = r_q_key - CNT_W'(1);
    assign ins_op     = (i_op == OP_INS_STACK) || (i_op == OP_INS_FRESH);
    assign ins_slot   = (i_op == OP_INS_STACK) ? r_fs_q : r_used[SLOT_W-1:0];
    assign box_we     = ins_op || (i_op == OP_UPDATE);
    assign ent_we     = ins_op;
    assign box_wa     = (i_op == OP_UPDATE) ? key_m1[SLOT_W-1:0] : ins_slot;
    assign box_wd     = r_q_box;
    assign fs_ra      = SLOT_W'(r_depth - CNT_W'(1));
    assign box_addr_a = r_in_pair ? r_b : r_s[SLOT_W-1:0];
    assign box_addr_b = r_in_pair ? r_ord_qb : r_t[SLOT_W-1:0];

    // rank order: X min value, then slot
    assign rk_less = s_lt(r_box_qb.lx, r_box_qa.lx) ||
                     ((r_box_qb.lx == r_box_qa.lx) && (r_pt < r_s[SLOT_W-1:0]));

    // port B holds the earlier box a, port A the box b being entered
    assign pr_act = !(!s_lt(r_box_qb.ux, r_box_qb.lx) && s_lt(r_box_qb.ux, r_box_qa.lx));
    assign pr_hit = pr_act &&
                    ov1(r_box_qb.ly, r_box_qb.uy, r_box_qa.ly, r_box_qa.uy) &&
                    ov1(r_box_qb.lz, r_box_qb.uz, r_box_qa.lz, r_box_qa.uz);
    assign ent_lo = (r_ent_qb > r_ent_qa) ? r_ent_qa : r_ent_qb;
    assign ent_hi = (r_ent_qb > r_ent_qa) ? r_ent_qb : r_ent_qa;
    assign pair_we = (i_op == OP_PR_STEP) && r_p2 && pr_hit &&
                     (r_stored < STORED_W'(MAX_PAIRS));

    assign q_hit = ov1(r_box_qa.lx, r_box_qa.ux, r_q_box.lx, r_q_box.ux) &&
                   ov1(r_box_qa.ly, r_box_qa.uy, r_q_box.ly, r_q_box.uy) &&
                   ov1(r_box_qa.lz, r_box_qa.uz, r_q_box.lz, r_q_box.uz);
    assign lim   = (r_q_lim > LIMIT_W'(RES_CAP)) ? LIMIT_W'(RES_CAP) : r_q_lim;

    assign out_free = !o_out_valid || i_out_ready;

    always_comb begin
        o_st.kind          = t_kind'(r_q_kind);
        o_st.free_nonempty = (r_depth != '0);
        o_st.slots_avail   = (r_used != CNT_W'(MAX_BOXES));
        o_st.key_ok        = (r_q_key != '0) && (key_m1 < r_used) &&
                             r_alive[key_m1[SLOT_W-1:0]];
        o_st.idx_ok        = ({1'b0, r_q_idx} < r_stored);
        o_st.s_end         = (r_s == r_used);
        o_st.s_alive       = r_alive[r_s[SLOT_W-1:0]];
        o_st.rk_done       = (r_t == r_used) && !r_p1;
        o_st.pr_end        = (r_s >= r_n);
        o_st.pr_done       = (r_t == r_s) && !r_p1 && !r_p2;
        o_st.q_stop        = (r_s == r_used) || (r_hits == CNT_W'(lim));
        o_st.q_hit         = q_hit;
        o_st.pend          = r_pend;
        o_st.out_free      = out_free;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (box_we) r_box_mem[box_wa] <= box_wd;
        r_box_qa <= r_box_mem[box_addr_a];
        r_box_qb <= r_box_mem[box_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) r_ent_mem[ins_slot] <= r_q_ent;
        r_ent_qa <= r_ent_mem[box_addr_a];
        r_ent_qb <= r_ent_mem[box_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_REMOVE) r_fs_mem[r_depth[SLOT_W-1:0]] <= key_m1[SLOT_W-1:0];
        r_fs_q <= r_fs_mem[fs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_RK_WRITE) r_ord_mem[r_cnt[SLOT_W-1:0]] <= r_s[SLOT_W-1:0];
        r_ord_qa <= r_ord_mem[r_s[SLOT_W-1:0]];
        r_ord_qb <= r_ord_mem[r_t[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (pair_we) r_pair_mem[r_stored[PAIR_W-1:0]] <= {ent_lo, ent_hi};
        r_pair_q <= r_pair_mem[r_pair_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive     <= '0;
            r_used      <= '0;
            r_depth     <= '0;
            r_stored    <= '0;
            r_ovf       <= 1'b0;
            r_in_pair   <= 1'b0;
            r_pend      <= 1'b0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (ins_op)             r_alive[ins_slot] <= 1'b1;
            if (i_op == OP_REMOVE)  r_alive[key_m1[SLOT_W-1:0]] <= 1'b0;
            if (i_op == OP_INS_STACK) r_depth <= r_depth - CNT_W'(1);
            if (i_op == OP_REMOVE)    r_depth <= r_depth + CNT_W'(1);
            if (i_op == OP_INS_FRESH) r_used <= r_used + CNT_W'(1);

            if (i_op == OP_RK_START || i_op == OP_Q_START) r_in_pair <= 1'b0;
            if (i_op == OP_PR_START) begin
                r_in_pair <= 1'b1;
                r_stored  <= '0;
                r_ovf     <= 1'b0;
            end
            if (i_op == OP_PR_STEP && r_p2 && pr_hit) begin
                if (r_stored < STORED_W'(MAX_PAIRS)) r_stored <= r_stored + STORED_W'(1);
                else                                 r_ovf <= 1'b1;
            end

            unique case (i_op)
                OP_RK_LOAD: r_p1 <= 1'b0;
                OP_RK_STEP: r_p1 <= (r_t < r_used);
                OP_PR_B: begin
                    r_p1 <= 1'b0;
                    r_p2 <= 1'b0;
                end
                OP_PR_STEP: begin
                    r_p1 <= (r_t < r_s);
                    r_p2 <= r_p1;
                end
                default: ;
            endcase

            if (i_op == OP_Q_START) r_pend <= 1'b0;
            if (i_op == OP_Q_TAKE)  r_pend <= 1'b1;

            // output word register
            if (i_op == OP_EMIT || i_op == OP_Q_SWAP || i_op == OP_Q_END)
                o_out_valid <= 1'b1;
            else if (i_out_ready)
                o_out_valid <= 1'b0;
        end
    end

    // payload and loop counters
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_CAP: begin
                r_q_kind   <= i_kind;
                r_q_key    <= i_box_key;
                r_q_ent    <= i_entity;
                r_q_box    <= '{lx: i_min_x, ly: i_min_y, lz: i_min_z,
                                ux: i_max_x, uy: i_max_y, uz: i_max_z};
                r_q_idx    <= i_pair_index;
                r_q_lim    <= i_hit_limit;
                r_res_key  <= '0;
                r_res_fail <= 1'b0;
                r_res_pair <= 1'b0;
            end
            OP_INS_STACK, OP_INS_FRESH: r_res_key <= KEY_W'({1'b0, ins_slot} + CNT_W'(1));
            OP_INS_FULL, OP_RD_BAD:     r_res_fail <= 1'b1;
            OP_RD_PAIR: begin
                r_pair_addr <= r_q_idx;
                r_res_pair  <= 1'b1;
            end
            OP_RK_START: begin
                r_s <= '0;
                r_n <= '0;
            end
            OP_RK_SKIP, OP_Q_NEXT, OP_PR_NEXT: r_s <= r_s + CNT_W'(1);
            OP_RK_LOAD: begin
                r_t   <= '0;
                r_cnt <= '0;
            end
            OP_RK_STEP: begin
                if (r_t < r_used) begin
                    r_t  <= r_t + CNT_W'(1);
                    r_pt <= r_t[SLOT_W-1:0];
                end
                if (r_p1 && r_alive[r_pt] && rk_less) r_cnt <= r_cnt + CNT_W'(1);
            end
            OP_RK_WRITE: begin
                r_n <= r_n + CNT_W'(1);
                r_s <= r_s + CNT_W'(1);
            end
            OP_PR_START: r_s <= CNT_W'(1);
            OP_PR_B: begin
                r_b <= r_ord_qa;
                r_t <= '0;
            end
            OP_PR_STEP: begin
                if (r_t < r_s) r_t <= r_t + CNT_W'(1);
            end
            OP_Q_START: begin
                r_s    <= '0;
                r_hits <= '0;
            end
            OP_Q_TAKE, OP_Q_SWAP: begin
                r_pend_ent <= r_ent_qa;
                r_hits     <= r_hits + CNT_W'(1);
                r_s        <= r_s + CNT_W'(1);
            end
            default: ;
        endcase
    end

    // output word fields
    always_ff @(posedge i_clk) begin
        if (i_op == OP_EMIT || i_op == OP_Q_SWAP || i_op == OP_Q_END) begin
            o_pair_count <= r_stored;
            o_overflow   <= r_ovf;
        end
        unique case (i_op)
            OP_EMIT: begin
                o_new_key     <= r_res_key;
                o_failure     <= r_res_fail;
                o_entity_low  <= r_res_pair ? r_pair_q[2*ENT_W-1:ENT_W] : '0;
                o_entity_high <= r_res_pair ? r_pair_q[ENT_W-1:0] : '0;
                o_hit_entity  <= '0;
                o_hit_valid   <= 1'b0;
                o_last        <= 1'b1;
            end
            OP_Q_SWAP, OP_Q_END: begin
                o_new_key     <= '0;
                o_failure     <= 1'b0;
                o_entity_low  <= '0;
                o_entity_high <= '0;
                o_hit_entity  <= r_pend ? r_pend_ent : '0;
                o_hit_valid   <= r_pend;
                o_last        <= (i_op == OP_Q_END);
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/sweep_and_prune_broadphase_core.sv =====
// Top level of the sweep-and-prune broadphase core: controller plus datapath.
// Depends on sap_pkg, sap_ctrl and sap_dpath.
//
//  channel  | handshake                   | word
//  ---------+-----------------------------+------------------------------------
//  input    | i_in_valid / o_in_ready     | kind, key, entity, bounds, index, limit
//  output   | o_out_valid / i_out_ready   | key, pair count, pair, hit, flags, last
//
// One input word at a time. Query: scans the used slots, skipping dead ones
// and testing alive ones, and waits on a stalled output. Step: X rank of the
// alive boxes over the used slots, then the sweep. Synchronous reset; no
// clearing pass.
// A stalled output holds its word and the controller waits on it.
`default_nettype none
module sweep_and_prune_broadphase_core
    import sap_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire [KIND_W-1:0]         i_kind,
    input  wire [KEY_W-1:0]          i_box_key,
    input  wire [ENT_W-1:0]          i_entity,
    input  wire signed [COORD_W-1:0] i_min_x,
    input  wire signed [COORD_W-1:0] i_min_y,
    input  wire signed [COORD_W-1:0] i_min_z,
    input  wire signed [COORD_W-1:0] i_max_x,
    input  wire signed [COORD_W-1:0] i_max_y,
    input  wire signed [COORD_W-1:0] i_max_z,
    input  wire [PAIR_W-1:0]         i_pair_index,
    input  wire [LIMIT_W-1:0]        i_hit_limit,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic [KEY_W-1:0]         o_new_key,
    output logic [STORED_W-1:0]      o_pair_count,
    output logic [ENT_W-1:0]         o_entity_low,
    output logic [ENT_W-1:0]         o_entity_high,
    output logic [ENT_W-1:0]         o_hit_entity,
    output logic                     o_hit_valid,
    output logic                     o_overflow,
    output logic                     o_failure,
    output logic                     o_last
);

    t_op     op;
    t_status st;

    sap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_op       (op)
    );

    sap_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .o_st          (st),
        .i_kind        (i_kind),
        .i_box_key     (i_box_key),
        .i_entity      (i_entity),
        .i_min_x       (i_min_x),
        .i_min_y       (i_min_y),
        .i_min_z       (i_min_z),
        .i_max_x       (i_max_x),
        .i_max_y       (i_max_y),
        .i_max_z       (i_max_z),
        .i_pair_index  (i_pair_index),
        .i_hit_limit   (i_hit_limit),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_new_key     (o_new_key),
        .o_pair_count  (o_pair_count),
        .o_entity_low  (o_entity_low),
        .o_entity_high (o_entity_high),
        .o_hit_entity  (o_hit_entity),
        .o_hit_valid   (o_hit_valid),
        .o_overflow    (o_overflow),
        .o_failure     (o_failure),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

// ===== src/sap_checker.sv =====
// Port-level checks on the result channel of the broadphase core, bound to
// the top level. Depends on sap_pkg for field widths.
`default_nettype none
module sap_checker
    import sap_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input wire [KEY_W-1:0]      o_new_key,
    input wire [ENT_W-1:0]      o_entity_low,
    input wire [ENT_W-1:0]      o_entity_high,
    input wire [ENT_W-1:0]      o_hit_entity,
    input wire                  o_hit_valid,
    input wire                  o_failure,
    input wire                  o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit_entity) && $stable(o_last))
        else $error("result word changed while stalled");

    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_failure |-> !o_hit_valid && o_new_key == '0 &&
                                     o_entity_low == '0 && o_entity_high == '0)
        else $error("failure word carries data");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entity_low <= o_entity_high)
        else $error("pair not ordered");

    a_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_new_key != '0 |-> o_last && !o_failure && !o_hit_valid)
        else $error("insert key with wrong flags");

    a_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit_valid |-> o_hit_entity == '0 && o_last)
        else $error("non-hit word not final or carries entity");

endmodule

bind sweep_and_prune_broadphase_core sap_checker u_sap_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_new_key     (o_new_key),
    .o_entity_low  (o_entity_low),
    .o_entity_high (o_entity_high),
    .o_hit_entity  (o_hit_entity),
    .o_hit_valid   (o_hit_valid),
    .o_failure     (o_failure),
    .o_last        (o_last)
);
`default_nettype wire
